// ===== rtl/qvr_pkg.sv =====
// shared types and widths for the quaternion vector rotation core
// no dependencies; used by quaternion_vector_rotate_core
package qvr_pkg;

   // field widths
   localparam int QUAT_W = 16;   // signed Q1.14
   localparam int VEC_W  = 32;   // signed Q16.16

   // internal widths
   localparam int PROD1_W = QUAT_W + VEC_W;        // q * v product
   localparam int P_W     = PROD1_W + 2;           // first quaternion product part
   localparam int COEF_W  = QUAT_W + 1;            // +/- quaternion part
   localparam int SPLIT_W = 25;                    // low slice of p
   localparam int PHI_W   = P_W - SPLIT_W;         // high slice of p
   localparam int HPROD_W = PHI_W + COEF_W;        // high partial product
   localparam int LPROD_W = SPLIT_W + 1 + COEF_W;  // low partial product
   localparam int HSUM_W  = HPROD_W + 2;
   localparam int LSUM_W  = LPROD_W + 2;
   localparam int TOT_W   = 70;
   localparam int RND_SH  = 28;                    // scale 2^44 down to 2^16
   localparam int RES_W   = TOT_W - RND_SH;

   typedef struct packed {
      logic signed [QUAT_W-1:0] quat_x;
      logic signed [QUAT_W-1:0] quat_y;
      logic signed [QUAT_W-1:0] quat_z;
      logic signed [QUAT_W-1:0] quat_w;
      logic signed [VEC_W-1:0]  vec_x;
      logic signed [VEC_W-1:0]  vec_y;
      logic signed [VEC_W-1:0]  vec_z;
   } req_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] rot_x;
      logic signed [VEC_W-1:0] rot_y;
      logic signed [VEC_W-1:0] rot_z;
      logic                    overflow;
   } rsp_type;

endpackage

// ===== rtl/quaternion_vector_rotate_core.sv =====
// Rotates a Q16.16 vector by a Q1.14 quaternion as q*(v,0)*conj(q), saturating the result.
// One item is taken every cycle unless every stage is full and the output is held. Each
// stage has its own valid bit and loads when it is empty or when
// the stage after it moves on, so bubbles close up and the core keeps taking items while
// a finished result waits, up to five items in flight. The stages are: q*v products,
// first quaternion product, split partial products of the second product, partial sums,
// and rounding with saturation into the output register. A quaternion that is not unit
// length scales the result by its squared norm; overflow flags any saturated component.
// Depends on qvr_pkg.
module quaternion_vector_rotate_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qvr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qvr_pkg::rsp_type rsp_data
);

   localparam int NSTG = 5;

   // stage control
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] adv;

   // stage 1: q*v products and quaternion copy
   logic signed [qvr_pkg::PROD1_W-1:0] prod_ff [12];
   logic signed [qvr_pkg::PROD1_W-1:0] prod_in [12];
   logic signed [qvr_pkg::QUAT_W-1:0]  q1_ff [4];

   // stage 2: p = q*(v,0), coefficients of the second product
   logic signed [qvr_pkg::P_W-1:0]    p_ff [4];
   logic signed [qvr_pkg::P_W-1:0]    p_in [4];
   logic signed [qvr_pkg::COEF_W-1:0] coef_ff [3][4];
   logic signed [qvr_pkg::COEF_W-1:0] coef_in [3][4];

   // stage 3: partial products
   logic signed [qvr_pkg::HPROD_W-1:0] hp_ff [3][4];
   logic signed [qvr_pkg::HPROD_W-1:0] hp_in [3][4];
   logic signed [qvr_pkg::LPROD_W-1:0] lp_ff [3][4];
   logic signed [qvr_pkg::LPROD_W-1:0] lp_in [3][4];

   // stage 4: partial sums
   logic signed [qvr_pkg::HSUM_W-1:0] hs_ff [3];
   logic signed [qvr_pkg::HSUM_W-1:0] hs_in [3];
   logic signed [qvr_pkg::LSUM_W-1:0] ls_ff [3];
   logic signed [qvr_pkg::LSUM_W-1:0] ls_in [3];

   // stage 5: output register
   qvr_pkg::rsp_type rsp_ff;
   qvr_pkg::rsp_type rsp_in;

   // stage advance chain and valid bits
   always_comb begin
      adv[NSTG-1] = !vld_ff[NSTG-1] || rsp_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1 logic: twelve 16x32 products
   always_comb begin
      prod_in[0]  = qvr_pkg::PROD1_W'(req_data.quat_x) * qvr_pkg::PROD1_W'(req_data.vec_x);
      prod_in[1]  = qvr_pkg::PROD1_W'(req_data.quat_y) * qvr_pkg::PROD1_W'(req_data.vec_y);
      prod_in[2]  = qvr_pkg::PROD1_W'(req_data.quat_z) * qvr_pkg::PROD1_W'(req_data.vec_z);
      prod_in[3]  = qvr_pkg::PROD1_W'(req_data.quat_w) * qvr_pkg::PROD1_W'(req_data.vec_x);
      prod_in[4]  = qvr_pkg::PROD1_W'(req_data.quat_y) * qvr_pkg::PROD1_W'(req_data.vec_z);
      prod_in[5]  = qvr_pkg::PROD1_W'(req_data.quat_z) * qvr_pkg::PROD1_W'(req_data.vec_y);
      prod_in[6]  = qvr_pkg::PROD1_W'(req_data.quat_w) * qvr_pkg::PROD1_W'(req_data.vec_y);
      prod_in[7]  = qvr_pkg::PROD1_W'(req_data.quat_z) * qvr_pkg::PROD1_W'(req_data.vec_x);
      prod_in[8]  = qvr_pkg::PROD1_W'(req_data.quat_x) * qvr_pkg::PROD1_W'(req_data.vec_z);
      prod_in[9]  = qvr_pkg::PROD1_W'(req_data.quat_w) * qvr_pkg::PROD1_W'(req_data.vec_z);
      prod_in[10] = qvr_pkg::PROD1_W'(req_data.quat_x) * qvr_pkg::PROD1_W'(req_data.vec_y);
      prod_in[11] = qvr_pkg::PROD1_W'(req_data.quat_y) * qvr_pkg::PROD1_W'(req_data.vec_x);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         prod_ff <= prod_in;
         q1_ff[0] <= req_data.quat_x;
         q1_ff[1] <= req_data.quat_y;
         q1_ff[2] <= req_data.quat_z;
         q1_ff[3] <= req_data.quat_w;
      end
   end

   // stage 2 logic: first Hamilton product, order w,x,y,z
   always_comb begin
      p_in[0] = -(qvr_pkg::P_W'(prod_ff[0]) + qvr_pkg::P_W'(prod_ff[1])
                  + qvr_pkg::P_W'(prod_ff[2]));
      p_in[1] = qvr_pkg::P_W'(prod_ff[3]) + qvr_pkg::P_W'(prod_ff[4])
                - qvr_pkg::P_W'(prod_ff[5]);
      p_in[2] = qvr_pkg::P_W'(prod_ff[6]) + qvr_pkg::P_W'(prod_ff[7])
                - qvr_pkg::P_W'(prod_ff[8]);
      p_in[3] = qvr_pkg::P_W'(prod_ff[9]) + qvr_pkg::P_W'(prod_ff[10])
                - qvr_pkg::P_W'(prod_ff[11]);
      // conj(q) coefficients per output component
      coef_in[0][0] = -qvr_pkg::COEF_W'(q1_ff[0]);
      coef_in[0][1] =  qvr_pkg::COEF_W'(q1_ff[3]);
      coef_in[0][2] = -qvr_pkg::COEF_W'(q1_ff[2]);
      coef_in[0][3] =  qvr_pkg::COEF_W'(q1_ff[1]);
      coef_in[1][0] = -qvr_pkg::COEF_W'(q1_ff[1]);
      coef_in[1][1] =  qvr_pkg::COEF_W'(q1_ff[2]);
      coef_in[1][2] =  qvr_pkg::COEF_W'(q1_ff[3]);
      coef_in[1][3] = -qvr_pkg::COEF_W'(q1_ff[0]);
      coef_in[2][0] = -qvr_pkg::COEF_W'(q1_ff[2]);
      coef_in[2][1] = -qvr_pkg::COEF_W'(q1_ff[1]);
      coef_in[2][2] =  qvr_pkg::COEF_W'(q1_ff[0]);
      coef_in[2][3] =  qvr_pkg::COEF_W'(q1_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         p_ff    <= p_in;
         coef_ff <= coef_in;
      end
   end

   // stage 3 logic: p split into signed high and unsigned low slice
   always_comb begin
      for (int o = 0; o < 3; o++) begin
         for (int t = 0; t < 4; t++) begin
            hp_in[o][t] = qvr_pkg::HPROD_W'($signed(p_ff[t][qvr_pkg::P_W-1:qvr_pkg::SPLIT_W]))
                          * qvr_pkg::HPROD_W'(coef_ff[o][t]);
            lp_in[o][t] = qvr_pkg::LPROD_W'($signed({1'b0, p_ff[t][qvr_pkg::SPLIT_W-1:0]}))
                          * qvr_pkg::LPROD_W'(coef_ff[o][t]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         hp_ff <= hp_in;
         lp_ff <= lp_in;
      end
   end

   // stage 4 logic: four-term sums
   always_comb begin
      for (int o = 0; o < 3; o++) begin
         hs_in[o] = qvr_pkg::HSUM_W'(hp_ff[o][0]) + qvr_pkg::HSUM_W'(hp_ff[o][1])
                  + qvr_pkg::HSUM_W'(hp_ff[o][2]) + qvr_pkg::HSUM_W'(hp_ff[o][3]);
         ls_in[o] = qvr_pkg::LSUM_W'(lp_ff[o][0]) + qvr_pkg::LSUM_W'(lp_ff[o][1])
                  + qvr_pkg::LSUM_W'(lp_ff[o][2]) + qvr_pkg::LSUM_W'(lp_ff[o][3]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         hs_ff <= hs_in;
         ls_ff <= ls_in;
      end
   end

   // stage 5 logic: recombine, round half up, saturate
   always_comb begin
      logic signed [qvr_pkg::TOT_W-1:0] tot;
      logic signed [qvr_pkg::RES_W-1:0] res;
      logic signed [qvr_pkg::VEC_W-1:0] sat [3];
      logic                             ovf;
      ovf = 1'b0;
      for (int o = 0; o < 3; o++) begin
         tot = (qvr_pkg::TOT_W'(hs_ff[o]) <<< qvr_pkg::SPLIT_W) + qvr_pkg::TOT_W'(ls_ff[o])
               + (qvr_pkg::TOT_W'(1) <<< (qvr_pkg::RND_SH - 1));
         res = tot[qvr_pkg::TOT_W-1:qvr_pkg::RND_SH];
         if (res[qvr_pkg::RES_W-1:qvr_pkg::VEC_W-1] == '0
             || res[qvr_pkg::RES_W-1:qvr_pkg::VEC_W-1] == '1) begin
            sat[o] = res[qvr_pkg::VEC_W-1:0];
         end else begin
            ovf    = 1'b1;
            sat[o] = res[qvr_pkg::RES_W-1] ? {1'b1, {(qvr_pkg::VEC_W-1){1'b0}}}
                                           : {1'b0, {(qvr_pkg::VEC_W-1){1'b1}}};
         end
      end
      rsp_in.rot_x    = sat[0];
      rsp_in.rot_y    = sat[1];
      rsp_in.rot_z    = sat[2];
      rsp_in.overflow = ovf;
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[NSTG-1];
   assign rsp_data  = rsp_ff;

   // input is refused only when every stage is full and the output is held
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&vld_ff) && !rsp_ready)
      else $error("input stalled while the pipeline has room");

   // an item in stage four moves into the output register when it advances
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[3] && adv[4]) |=> vld_ff[4])
      else $error("item lost between last two stages");

   // overflow flag only with a component at a rail
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.overflow) |->
         (rsp_data.rot_x == {1'b0, {(qvr_pkg::VEC_W-1){1'b1}}}
          || rsp_data.rot_x == {1'b1, {(qvr_pkg::VEC_W-1){1'b0}}}
          || rsp_data.rot_y == {1'b0, {(qvr_pkg::VEC_W-1){1'b1}}}
          || rsp_data.rot_y == {1'b1, {(qvr_pkg::VEC_W-1){1'b0}}}
          || rsp_data.rot_z == {1'b0, {(qvr_pkg::VEC_W-1){1'b1}}}
          || rsp_data.rot_z == {1'b1, {(qvr_pkg::VEC_W-1){1'b0}}}))
      else $error("overflow set without a saturated component");

endmodule
